### design/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants for the touch gesture classifier: gesture codes,
// register indexes, register reset values and the packed register set.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

    // Field widths fixed by the register map and the sample format
    localparam int CNT_W      = 2;
    localparam int TIME_CFG_W = 16;
    localparam int DIST_W     = 12;
    localparam int ELAPSED_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GEST_W     = 3;

    // Gesture codes
    typedef enum logic [GEST_W-1:0] {
        GEST_NONE    = 3'd0,
        GEST_TAP     = 3'd1,
        GEST_TWO_TAP = 3'd2,
        GEST_LEFT    = 3'd3,
        GEST_RIGHT   = 3'd4,
        GEST_UP      = 3'd5,
        GEST_DOWN    = 3'd6
    } t_gesture;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TRAVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MIN   = 2'd2;

    // Register reset values
    localparam logic [TIME_CFG_W-1:0] TAP_TIME_RST   = 16'd600;
    localparam logic [DIST_W-1:0]     TAP_TRAVEL_RST = 12'd12;
    localparam logic [DIST_W-1:0]     SWIPE_MIN_RST  = 12'd30;

    // Finger count values
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MANY = 2'd3;

    // Register set
    typedef struct packed {
        logic [TIME_CFG_W-1:0] tap_time_limit;
        logic [DIST_W-1:0]     tap_travel_limit;
        logic [DIST_W-1:0]     swipe_travel_min;
    } t_tgc_cfg;

    // Result of one sample
    typedef struct packed {
        t_gesture gesture;
        logic     session_active;
    } t_tgc_result;

endpackage

`default_nettype wire

### design/tgc_if.sv
// ----------------------------------------------------------------------------
// tgc_if
// Valid/ready channels of the classifier: touch samples, results and the
// register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgc_sample_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            finger_count;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
    logic [15:0]           elapsed_ms;

    modport source (
        output valid, finger_count, first_x, first_y, second_x, second_y, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, finger_count, first_x, first_y, second_x, second_y, elapsed_ms,
        output ready
    );
endinterface

interface tgc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] gesture;
    logic       session_active;

    modport source (output valid, gesture, session_active, input ready);
    modport sink   (input  valid, gesture, session_active, output ready);
endinterface

interface tgc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

### design/tgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tgc_cfg_regs
// Threshold registers, written through the register port. Writes to an
// unused index are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_cfg_regs
    import tgc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_tgc_cfg                   o_cfg
);

    t_tgc_cfg r_cfg;
    t_tgc_cfg n_cfg;

    // Register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_TAP_TIME:   n_cfg.tap_time_limit   = i_data[TIME_CFG_W-1:0];
                CFG_TAP_TRAVEL: n_cfg.tap_travel_limit = i_data[DIST_W-1:0];
                CFG_SWIPE_MIN:  n_cfg.swipe_travel_min = i_data[DIST_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_time_limit   <= TAP_TIME_RST;
            r_cfg.tap_travel_limit <= TAP_TRAVEL_RST;
            r_cfg.swipe_travel_min <= SWIPE_MIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/tgc_classify.sv
// ----------------------------------------------------------------------------
// tgc_classify
// Classifies a finished session from the stored slot state: tap, two-finger
// tap, one-finger swipe direction or none.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_classify
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 24
) (
    input  t_tgc_cfg                         i_cfg,
    input  wire logic [CNT_W-1:0]            i_peak_fingers,
    input  wire logic [TIME_BITS-1:0]        i_held_time,
    input  wire logic [1:0][COORD_BITS-1:0]  i_origin_x,
    input  wire logic [1:0][COORD_BITS-1:0]  i_origin_y,
    input  wire logic [1:0][COORD_BITS-1:0]  i_latest_x,
    input  wire logic [1:0][COORD_BITS-1:0]  i_latest_y,
    input  wire logic [1:0][COORD_BITS-1:0]  i_peak_travel,
    output t_gesture                         o_gesture
);

    localparam int CW = (COORD_BITS > DIST_W) ? COORD_BITS : DIST_W;

    logic                         sel;
    logic [COORD_BITS-1:0]        travel;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]          dx_mag;
    logic [COORD_BITS:0]          dy_mag;
    logic                         is_tap;
    logic                         is_swipe;

    // Slot one wins only on strictly larger travel
    assign sel    = i_peak_travel[1] > i_peak_travel[0];
    assign travel = i_peak_travel[sel];
    assign dx     = $signed({1'b0, i_latest_x[sel]}) - $signed({1'b0, i_origin_x[sel]});
    assign dy     = $signed({1'b0, i_latest_y[sel]}) - $signed({1'b0, i_origin_y[sel]});
    assign dx_mag = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
    assign dy_mag = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;

    // Threshold tests
    assign is_tap   = (CW'(travel) <= CW'(i_cfg.tap_travel_limit))
                   && (i_held_time <= TIME_BITS'(i_cfg.tap_time_limit));
    assign is_swipe = (CW'(travel) >= CW'(i_cfg.swipe_travel_min))
                   && (i_peak_fingers == CNT_ONE);

    // Decision; a diagonal counts as horizontal
    always_comb begin
        if (is_tap) begin
            o_gesture = (i_peak_fingers >= CNT_TWO) ? GEST_TWO_TAP : GEST_TAP;
        end else if (is_swipe) begin
            if (dx_mag >= dy_mag) begin
                o_gesture = dx[COORD_BITS] ? GEST_LEFT : GEST_RIGHT;
            end else begin
                o_gesture = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
            end
        end else begin
            o_gesture = GEST_NONE;
        end
    end

endmodule

`default_nettype wire

### design/tgc_session.sv
// ----------------------------------------------------------------------------
// tgc_session
// Session state and its update for one sample: held time, peak finger count,
// per-slot origin, last position and peak travel.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_session
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  t_tgc_cfg                          i_cfg,
    input  wire logic [CNT_W-1:0]             i_count,
    input  wire logic [1:0][COORD_BITS-1:0]   i_x,
    input  wire logic [1:0][COORD_BITS-1:0]   i_y,
    input  wire logic [ELAPSED_W-1:0]         i_elapsed,
    output t_tgc_result                       o_result
);

    // Session state
    logic                        r_active,   n_active;
    logic [CNT_W-1:0]            r_peak,     n_peak;
    logic [CNT_W-1:0]            r_prev,     n_prev;
    logic [TIME_BITS-1:0]        r_held,     n_held;
    logic [1:0]                  r_present,  n_present;
    logic [1:0][COORD_BITS-1:0]  r_origin_x, n_origin_x;
    logic [1:0][COORD_BITS-1:0]  r_origin_y, n_origin_y;
    logic [1:0][COORD_BITS-1:0]  r_latest_x, n_latest_x;
    logic [1:0][COORD_BITS-1:0]  r_latest_y, n_latest_y;
    logic [1:0][COORD_BITS-1:0]  r_travel,   n_travel;

    logic [CNT_W-1:0]            count;
    logic [ELAPSED_W-1:0]        dt;
    logic [TIME_BITS:0]          held_sum;
    logic                        changed;
    logic [1:0][COORD_BITS-1:0]  dist_x;
    logic [1:0][COORD_BITS-1:0]  dist_y;
    logic [1:0][COORD_BITS-1:0]  span;
    t_gesture                    gesture;

    tgc_classify #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_classify (
        .i_cfg          (i_cfg),
        .i_peak_fingers (r_peak),
        .i_held_time    (r_held),
        .i_origin_x     (r_origin_x),
        .i_origin_y     (r_origin_y),
        .i_latest_x     (r_latest_x),
        .i_latest_y     (r_latest_y),
        .i_peak_travel  (r_travel),
        .o_gesture      (gesture)
    );

    // Input clean-up: clamp count, zero time counts as one
    assign count    = (i_count == CNT_MANY) ? CNT_TWO : i_count;
    assign dt       = (i_elapsed == '0) ? ELAPSED_W'(1) : i_elapsed;
    assign held_sum = {1'b0, r_held} + (TIME_BITS+1)'(dt);

    // Chebyshev distance of each slot from its stored origin
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            dist_x[i] = (i_x[i] > r_origin_x[i]) ? i_x[i] - r_origin_x[i]
                                                 : r_origin_x[i] - i_x[i];
            dist_y[i] = (i_y[i] > r_origin_y[i]) ? i_y[i] - r_origin_y[i]
                                                 : r_origin_y[i] - i_y[i];
            span[i]   = (dist_y[i] > dist_x[i]) ? dist_y[i] : dist_x[i];
        end
    end

    // Next session state
    always_comb begin
        n_active   = r_active;
        n_peak     = r_peak;
        n_prev     = r_prev;
        n_held     = r_held;
        n_present  = r_present;
        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        n_latest_x = r_latest_x;
        n_latest_y = r_latest_y;
        n_travel   = r_travel;
        changed    = 1'b0;
        if (i_step) begin
            if (count == CNT_NONE) begin
                // Release ends any open session
                if (r_active) begin
                    n_active  = 1'b0;
                    n_peak    = '0;
                    n_prev    = '0;
                    n_held    = '0;
                    n_present = '0;
                    n_travel  = '0;
                end
            end else begin
                if (!r_active) begin
                    n_active  = 1'b1;
                    n_peak    = '0;
                    n_prev    = '0;
                    n_held    = '0;
                    n_present = '0;
                end else begin
                    n_held = held_sum[TIME_BITS] ? '1 : held_sum[TIME_BITS-1:0];
                end
                if (count > n_peak) begin
                    n_peak = count;
                end
                changed = (count != n_prev);
                n_prev  = count;
                for (int i = 0; i < 2; i++) begin
                    if (CNT_W'(i) >= count) begin
                        n_present[i] = 1'b0;
                    end else if (!n_present[i]) begin
                        // Slot newly down: fresh origin, travel restarts
                        n_present[i]  = 1'b1;
                        n_origin_x[i] = i_x[i];
                        n_origin_y[i] = i_y[i];
                        n_latest_x[i] = i_x[i];
                        n_latest_y[i] = i_y[i];
                        n_travel[i]   = '0;
                    end else begin
                        n_latest_x[i] = i_x[i];
                        n_latest_y[i] = i_y[i];
                        if (changed) begin
                            // Count changed: re-latch origin, travel kept
                            n_origin_x[i] = i_x[i];
                            n_origin_y[i] = i_y[i];
                        end else if (span[i] > r_travel[i]) begin
                            n_travel[i] = span[i];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_peak     <= '0;
            r_prev     <= '0;
            r_held     <= '0;
            r_present  <= '0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_latest_x <= '0;
            r_latest_y <= '0;
            r_travel   <= '0;
        end else begin
            r_active   <= n_active;
            r_peak     <= n_peak;
            r_prev     <= n_prev;
            r_held     <= n_held;
            r_present  <= n_present;
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            r_latest_x <= n_latest_x;
            r_latest_y <= n_latest_y;
            r_travel   <= n_travel;
        end
    end

    // Result of this sample
    assign o_result.gesture        = (count == CNT_NONE && r_active) ? gesture : GEST_NONE;
    assign o_result.session_active = (count != CNT_NONE);

    // A release always leaves the block idle
    a_release_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && count == CNT_NONE) |=> !r_active)
        else $error("session still open after release");

    // Held time only runs inside a session
    a_idle_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_held == '0 && r_present == '0 && r_peak == '0))
        else $error("stale session state while idle");

    // An open session always has seen at least one finger
    a_active_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_peak != CNT_NONE))
        else $error("open session without a finger");

endmodule

`default_nettype wire

### design/touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Touch-sample gesture classifier: tracks a touch session across samples and
// reports tap, two-finger tap or swipe direction when all fingers lift.
//
//   channel   dir  handshake      carries
//   i_sample  in   valid/ready    finger_count, first/second x/y, elapsed_ms
//   o_result  out  valid/ready    gesture, session_active
//   i_cfg     in   valid/ready    index, data (thresholds)
//
// One sample per cycle while results are taken; an accepted sample passes the
// input register, then the result register. The rate is set by the session
// update, which reads and writes the session state in the same cycle.
// Reset loads the threshold defaults and closes any session.
// A stalled result holds the input register; the input stays ready while the
// input register is empty or drains into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_classifier
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tgc_cfg_if.sink      i_cfg,
    tgc_sample_if.sink   i_sample,
    tgc_result_if.source o_result
);

    t_tgc_cfg                    cfg;
    t_tgc_result                 step_result;
    logic                        advance;
    logic                        in_accept;

    // Input register
    logic                        r_in_valid;
    logic [CNT_W-1:0]            r_count;
    logic [1:0][COORD_BITS-1:0]  r_x;
    logic [1:0][COORD_BITS-1:0]  r_y;
    logic [ELAPSED_W-1:0]        r_elapsed;

    // Result register
    logic                        r_out_valid;
    t_tgc_result                 r_out;

    // Configuration
    assign i_cfg.ready = 1'b1;

    tgc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // Handshake
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_accept      = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_count   <= i_sample.finger_count;
            r_x       <= {i_sample.second_x, i_sample.first_x};
            r_y       <= {i_sample.second_y, i_sample.first_y};
            r_elapsed <= i_sample.elapsed_ms;
        end
    end

    // Session update
    tgc_session #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_session (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_cfg     (cfg),
        .i_count   (r_count),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_elapsed (r_elapsed),
        .o_result  (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.gesture        = r_out.gesture;
    assign o_result.session_active = r_out.session_active;

    // A processed sample lands in the result register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed sample produced no result");

    // The input register never advances into an occupied, stalled result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !advance)
        else $error("result overwritten while stalled");

    // A gesture is only reported on a release
    a_gesture_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.gesture != GEST_NONE) |-> !r_out.session_active)
        else $error("gesture reported while session active");

endmodule

`default_nettype wire

### tb/tgc_gesture_checker.sv
// ----------------------------------------------------------------------------
// tgc_gesture_checker
// Watches the register, sample and result channels of the gesture classifier.
// Keeps its own copy of the touch session and thresholds, works out the result
// of every accepted sample and compares it with what the block returns.
// ----------------------------------------------------------------------------
module tgc_gesture_checker
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 24
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tgc_cfg_if      i_cfg,
    tgc_sample_if   i_sample,
    tgc_result_if   i_result,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Thresholds as last written
    t_tgc_cfg thr;

    // Session copy
    logic                  in_session;
    logic [1:0]            max_fingers;
    logic [1:0]            last_fingers;
    logic [TIME_BITS-1:0]  hold_ms;
    logic                  slot_down  [2];
    logic [COORD_BITS-1:0] start_x    [2];
    logic [COORD_BITS-1:0] start_y    [2];
    logic [COORD_BITS-1:0] cur_x      [2];
    logic [COORD_BITS-1:0] cur_y      [2];
    logic [COORD_BITS-1:0] max_travel [2];

    t_tgc_result gesture_due [$];
    t_tgc_result want;
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, exp_val);
        fail_total++;
    endtask

    // Close the session; positions survive until overwritten
    function automatic void clear_session();
        in_session   = 1'b0;
        max_fingers  = CNT_NONE;
        last_fingers = CNT_NONE;
        hold_ms      = '0;
        for (int i = 0; i < 2; i++) begin
            slot_down[i]  = 1'b0;
            max_travel[i] = '0;
        end
    endfunction

    // Session update for one sample, returning the result it produces
    function automatic t_tgc_result classify_touch(
        input logic [1:0]            fc,
        input logic [COORD_BITS-1:0] x0, y0, x1, y1,
        input logic [15:0]           ms
    );
        logic [1:0]              cnt;
        logic [TIME_BITS:0]      sum;
        logic [COORD_BITS-1:0]   px [2];
        logic [COORD_BITS-1:0]   py [2];
        logic                    regrip;
        logic [COORD_BITS-1:0]   d, e, travel;
        logic signed [COORD_BITS:0] dx, dy, adx, ady;
        t_tgc_result             r;

        cnt = (fc == CNT_MANY) ? CNT_TWO : fc;
        r.gesture        = GEST_NONE;
        r.session_active = 1'b0;

        // All fingers up: classify a live session, ignore otherwise
        if (cnt == CNT_NONE) begin
            if (in_session) begin
                travel = max_travel[0];
                dx     = $signed({1'b0, cur_x[0]}) - $signed({1'b0, start_x[0]});
                dy     = $signed({1'b0, cur_y[0]}) - $signed({1'b0, start_y[0]});
                // slot one only wins with strictly more travel
                if (max_travel[1] > travel) begin
                    travel = max_travel[1];
                    dx     = $signed({1'b0, cur_x[1]}) - $signed({1'b0, start_x[1]});
                    dy     = $signed({1'b0, cur_y[1]}) - $signed({1'b0, start_y[1]});
                end
                if (travel <= thr.tap_travel_limit && hold_ms <= thr.tap_time_limit) begin
                    r.gesture = (max_fingers >= CNT_TWO) ? GEST_TWO_TAP : GEST_TAP;
                end else if (travel >= thr.swipe_travel_min && max_fingers == CNT_ONE) begin
                    adx = (dx < 0) ? -dx : dx;
                    ady = (dy < 0) ? -dy : dy;
                    // equal magnitudes go horizontal, zero dx counts as right
                    if (adx >= ady)
                        r.gesture = (dx < 0) ? GEST_LEFT : GEST_RIGHT;
                    else
                        r.gesture = (dy < 0) ? GEST_UP : GEST_DOWN;
                end
                clear_session();
            end
            return r;
        end

        px[0] = x0;
        py[0] = y0;
        px[1] = x1;
        py[1] = y1;

        // Opening sample leaves held time at zero; later ones add dt, saturating
        if (!in_session) begin
            in_session   = 1'b1;
            max_fingers  = CNT_NONE;
            last_fingers = CNT_NONE;
            hold_ms      = '0;
            slot_down[0] = 1'b0;
            slot_down[1] = 1'b0;
        end else begin
            sum     = {1'b0, hold_ms} + (TIME_BITS+1)'((ms == '0) ? 16'd1 : ms);
            hold_ms = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end

        if (cnt > max_fingers)
            max_fingers = cnt;
        regrip       = (cnt != last_fingers);
        last_fingers = cnt;

        // Per-slot tracking of origin, position and peak travel
        for (int i = 0; i < 2; i++) begin
            if (i >= cnt) begin
                slot_down[i] = 1'b0;
            end else if (!slot_down[i]) begin
                slot_down[i]  = 1'b1;
                start_x[i]    = px[i];
                cur_x[i]      = px[i];
                start_y[i]    = py[i];
                cur_y[i]      = py[i];
                max_travel[i] = '0;
            end else begin
                if (regrip) begin
                    start_x[i] = px[i];
                    start_y[i] = py[i];
                end
                cur_x[i] = px[i];
                cur_y[i] = py[i];
                d = (px[i] > start_x[i]) ? px[i] - start_x[i] : start_x[i] - px[i];
                e = (py[i] > start_y[i]) ? py[i] - start_y[i] : start_y[i] - py[i];
                if (e > d)
                    d = e;
                if (d > max_travel[i])
                    max_travel[i] = d;
            end
        end

        r.session_active = 1'b1;
        return r;
    endfunction

    // Follow every transaction on the three channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr.tap_time_limit   = TAP_TIME_RST;
            thr.tap_travel_limit = TAP_TRAVEL_RST;
            thr.swipe_travel_min = SWIPE_MIN_RST;
            clear_session();
            for (int i = 0; i < 2; i++) begin
                start_x[i] = '0;
                start_y[i] = '0;
                cur_x[i]   = '0;
                cur_y[i]   = '0;
            end
            gesture_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_TAP_TIME:   thr.tap_time_limit   = i_cfg.data;
                    CFG_TAP_TRAVEL: thr.tap_travel_limit = i_cfg.data[DIST_W-1:0];
                    CFG_SWIPE_MIN:  thr.swipe_travel_min = i_cfg.data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready) begin
                gesture_due.push_back(classify_touch(i_sample.finger_count,
                    i_sample.first_x, i_sample.first_y,
                    i_sample.second_x, i_sample.second_y, i_sample.elapsed_ms));
            end
            if (i_result.valid && i_result.ready) begin
                if (gesture_due.size() == 0) begin
                    report_mismatch("unexpected result, gesture", 32'(i_result.gesture), 'x);
                end else begin
                    want = gesture_due.pop_front();
                    if (i_result.gesture !== want.gesture)
                        report_mismatch("gesture", 32'(i_result.gesture),
                                        32'(want.gesture));
                    if (i_result.session_active !== want.session_active)
                        report_mismatch("session_active", 32'(i_result.session_active),
                                        32'(want.session_active));
                end
            end
        end
        o_pending <= gesture_due.size();
    end

endmodule

### tb/tb_touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// tb_touch_gesture_classifier
// Drives touch sessions into the gesture classifier: a directed set covering
// taps, swipes in every direction and the corner cases, then random sessions
// under several threshold settings with random gaps and result back-pressure.
// Checking is done by tgc_gesture_checker alongside the block.
// ----------------------------------------------------------------------------
module tb_touch_gesture_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import tgc_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 24;
    localparam int IDLE_LIMIT = 2000;   // cycles without any transaction
    localparam int LONG_HOLD  = 48;     // result stall long enough to fill the block
    localparam int SETTLE     = 8;      // quiet cycles before the verdict

    // Index outside the register map
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    bit          steady       = 1'b0;   // no gaps on either side
    bit          hold_off_req = 1'b0;
    int unsigned sent_count   = 0;
    int          idle_cycles  = 0;
    int          fail_count;
    int          pending;

    tgc_cfg_if                              cfg_bus ();
    tgc_sample_if #(.COORD_BITS(COORD_BITS)) sample_bus ();
    tgc_result_if                           result_bus ();

    touch_gesture_classifier #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_sample (sample_bus),
        .o_result (result_bus)
    );

    tgc_gesture_checker #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_sample     (sample_bus),
        .i_result     (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_ms();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 75) return 16'($urandom_range(1, 150));
        if (r < 92) return 16'($urandom_range(150, 2000));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Random step around a coordinate, kept on the panel
    function automatic int nudge(input int v, input int unsigned step);
        int n;
        n = v + int'($urandom_range(0, 2 * step)) - int'(step);
        if (n < 0) return 0;
        if (n > 4095) return 4095;
        return n;
    endfunction

    // One sample transaction, then an optional gap with valid low
    task automatic send_touch(input logic [1:0] fc, input logic [11:0] x0, y0, x1, y1,
                              input logic [15:0] ms);
        int unsigned gap;
        sample_bus.valid        <= 1'b1;
        sample_bus.finger_count <= fc;
        sample_bus.first_x      <= x0;
        sample_bus.first_y      <= y0;
        sample_bus.second_x     <= x1;
        sample_bus.second_y     <= y1;
        sample_bus.elapsed_ms   <= ms;
        do @(posedge i_clk); while (!sample_bus.ready);
        sent_count++;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering samples and wait for every outstanding result
    task automatic drain();
        sample_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write all registers plus the unused index; upper bits of narrow fields are junk
    task automatic configure(input logic [15:0] tap_time, input logic [11:0] tap_travel,
                             input logic [11:0] swipe_min);
        logic [3:0]  junk;
        logic [15:0] spare;
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_TAP_TIME;
        cfg_bus.data  <= tap_time;
        do @(posedge i_clk); while (!cfg_bus.ready);
        junk = 4'($urandom_range(0, 15));
        cfg_bus.index <= CFG_TAP_TRAVEL;
        cfg_bus.data  <= {junk, tap_travel};
        do @(posedge i_clk); while (!cfg_bus.ready);
        junk = 4'($urandom_range(0, 15));
        cfg_bus.index <= CFG_SWIPE_MIN;
        cfg_bus.data  <= {junk, swipe_min};
        do @(posedge i_clk); while (!cfg_bus.ready);
        spare = 16'($urandom_range(0, 65535));
        cfg_bus.index <= CFG_SPARE;
        cfg_bus.data  <= spare;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // A well-formed session: wandering fingers, occasional count changes, then release
    task automatic random_session();
        int unsigned len, step, k;
        int          ax, ay, bx, by;
        logic [1:0]  fc;
        len = $urandom_range(1, 10);
        case ($urandom_range(0, 2))
            0:       step = 4;
            1:       step = 20;
            default: step = 150;
        endcase
        ax = $urandom_range(0, 4095);
        ay = $urandom_range(0, 4095);
        bx = $urandom_range(0, 4095);
        by = $urandom_range(0, 4095);
        fc = ($urandom_range(0, 2) == 0) ? CNT_W'($urandom_range(2, 3)) : CNT_ONE;
        for (k = 0; k < len; k++) begin
            if (k != 0) begin
                if ($urandom_range(0, 5) == 0)
                    fc = CNT_W'($urandom_range(1, 3));
                ax = nudge(ax, step);
                ay = nudge(ay, step);
                bx = nudge(bx, step);
                by = nudge(by, step);
            end
            send_touch(fc, 12'(ax), 12'(ay), 12'(bx), 12'(by), pick_ms());
        end
        send_touch(CNT_NONE, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), pick_ms());
    endtask

    // Mostly sessions, some raw noise; closes any open session and drains
    task automatic run_phase(input int unsigned n_items);
        int unsigned first;
        first = sent_count;
        while (sent_count - first < n_items) begin
            if ($urandom_range(0, 9) == 0)
                send_touch(CNT_W'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                           12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
            else
                random_session();
        end
        send_touch(CNT_NONE, '0, '0, '0, '0, '0);
        drain();
    endtask

    // Result side: random stalls, or a long hold-off on request
    initial begin
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (steady || $urandom_range(0, 3) != 0) begin
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        int unsigned k;

        sample_bus.valid        <= 1'b0;
        sample_bus.finger_count <= CNT_NONE;
        sample_bus.first_x      <= '0;
        sample_bus.first_y      <= '0;
        sample_bus.second_x     <= '0;
        sample_bus.second_y     <= '0;
        sample_bus.elapsed_ms   <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= CFG_TAP_TIME;
        cfg_bus.data            <= '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases at reset thresholds
        // release with no session open
        send_touch(CNT_NONE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF);
        // tap, zero dt counted as one
        send_touch(CNT_ONE, 12'd100, 12'd100, 12'd0, 12'd0, 16'd0);
        send_touch(CNT_ONE, 12'd103, 12'd98, 12'd0, 12'd0, 16'd0);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd5);
        // two-finger tap with a count of three
        send_touch(CNT_MANY, 12'd0, 12'd0, 12'd4095, 12'd4095, 16'd300);
        send_touch(CNT_MANY, 12'd5, 12'd0, 12'd4090, 12'd4095, 16'd300);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd1);
        // diagonal, equal magnitudes: right
        send_touch(CNT_ONE, 12'd2000, 12'd2000, 12'd0, 12'd0, 16'd20);
        send_touch(CNT_ONE, 12'd2040, 12'd1960, 12'd0, 12'd0, 16'd20);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd20);
        // full-panel diagonal: left
        send_touch(CNT_ONE, 12'd4095, 12'd0, 12'd0, 12'd0, 16'd16);
        send_touch(CNT_ONE, 12'd0, 12'd4095, 12'd0, 12'd0, 16'd16);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd16);
        // up
        send_touch(CNT_ONE, 12'd500, 12'd500, 12'd0, 12'd0, 16'd30);
        send_touch(CNT_ONE, 12'd505, 12'd440, 12'd0, 12'd0, 16'd30);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd30);
        // second finger joins (origin relatch), travels most, then lifts first
        send_touch(CNT_ONE, 12'd100, 12'd100, 12'd0, 12'd0, 16'd10);
        send_touch(CNT_TWO, 12'd100, 12'd100, 12'd800, 12'd800, 16'd10);
        send_touch(CNT_TWO, 12'd102, 12'd100, 12'd800, 12'd860, 16'd10);
        send_touch(CNT_ONE, 12'd104, 12'd100, 12'd0, 12'd0, 16'd10);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd10);
        // out and back to the origin: dx of zero counts as right
        send_touch(CNT_ONE, 12'd200, 12'd200, 12'd0, 12'd0, 16'd10);
        send_touch(CNT_ONE, 12'd260, 12'd200, 12'd0, 12'd0, 16'd10);
        send_touch(CNT_ONE, 12'd200, 12'd200, 12'd0, 12'd0, 16'd10);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'd10);
        drain();

        // Lower extremes of every threshold
        configure(16'd0, 12'd0, 12'd0);
        run_phase(150);

        // Upper extremes; a long hold saturates held time, so no tap.
        // The result side holds off meanwhile so the block backs up.
        configure(16'hFFFF, 12'hFFF, 12'hFFF);
        steady       = 1'b1;
        hold_off_req = 1'b1;
        for (k = 0; k < 258; k++)
            send_touch(CNT_ONE, 12'd2048, 12'd2048, 12'd0, 12'd0, 16'hFFFF);
        send_touch(CNT_NONE, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF);
        steady = 1'b0;
        run_phase(60);

        // Random thresholds in the useful range, first with no idling at all
        configure(16'($urandom_range(0, 1500)), 12'($urandom_range(0, 40)),
                  12'($urandom_range(0, 120)));
        steady = 1'b1;
        run_phase(180);
        steady = 1'b0;
        configure(16'($urandom_range(0, 1500)), 12'($urandom_range(0, 40)),
                  12'($urandom_range(0, 120)));
        run_phase(180);

        // Back to the reset values
        configure(TAP_TIME_RST, TAP_TRAVEL_RST, SWIPE_MIN_RST);
        run_phase(200);

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
